// File: design/dtfe_pkg.sv
package dtfe_pkg;

  // Item kinds
  localparam logic [2:0] KIND_UP    = 3'd0;
  localparam logic [2:0] KIND_DOWN  = 3'd1;
  localparam logic [2:0] KIND_LEFT  = 3'd2;
  localparam logic [2:0] KIND_RIGHT = 3'd3;
  localparam logic [2:0] KIND_INC   = 3'd4;
  localparam logic [2:0] KIND_DEC   = 3'd5;
  localparam logic [2:0] KIND_LOAD  = 3'd6;
  localparam logic [2:0] KIND_NONE  = 3'd7;

  // Menu rows
  localparam logic [1:0] ROW_TIME   = 2'd0;
  localparam logic [1:0] ROW_LAST   = 2'd2;

  // Field cursor positions
  localparam logic [2:0] FLD_YEAR100 = 3'd0;
  localparam logic [2:0] FLD_YEAR10  = 3'd1;
  localparam logic [2:0] FLD_YEAR1   = 3'd2;
  localparam logic [2:0] FLD_MONTH   = 3'd3;
  localparam logic [2:0] FLD_DAY     = 3'd4;
  localparam logic [2:0] FLD_HOUR    = 3'd5;
  localparam logic [2:0] FLD_MINUTE  = 3'd6;
  localparam logic [2:0] FLD_LAST    = 3'd6;

  // Year saturation limits
  localparam logic [11:0] YEAR100_UP_MAX = 12'd2899;
  localparam logic [11:0] YEAR10_UP_MAX  = 12'd2989;
  localparam logic [11:0] YEAR1_UP_MAX   = 12'd2998;
  localparam logic [11:0] YEAR100_DN_MIN = 12'd1000;
  localparam logic [11:0] YEAR10_DN_MIN  = 12'd100;
  localparam logic [11:0] YEAR1_DN_MIN   = 12'd1;
  localparam logic [11:0] YEAR_STEP100   = 12'd100;
  localparam logic [11:0] YEAR_STEP10    = 12'd10;
  localparam logic [11:0] YEAR_STEP1     = 12'd1;

  // Wrap limits
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // Reset date-time
  localparam logic [11:0] YEAR_RST = 12'd2000;

  // Last day of the month; zero for a month code outside the calendar
  function automatic logic [4:0] month_last_day(input logic [3:0] month,
                                                input logic [11:0] year);
    logic [4:0] last;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: last = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     last = 5'd30;
      4'd2:    last = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: last = 5'd0;
    endcase
    return last;
  endfunction

endpackage

// File: design/date_time_field_editor.sv
// Date-time field editor for a clock-setting menu.
// Input channel in_*: one word per button event or RTC load. The kind sits
// in in_tuser, the date-time to load in in_tdata (used by a load only).
// Output channel out_*: one word per input word, carrying the date-time,
// menu row and field cursor as they stand after that event.
// An accepted word enters an input register; when the output register can
// advance, it updates the state and its result lands in the output register.
// Throughput: one word per cycle while out_tready stays high; the state update is a
// single pass of small compare and add logic between the input and output registers.
// When the receiver stalls, the output word holds and the input register
// keeps one more word; in_tready drops only once both are full.
// Reset (rst_n low, synchronous) empties both registers and sets the time
// row, year hundreds cursor and 2000-01-01 00:00.
module date_time_field_editor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // kind
  input  logic [31:0] in_tdata,   // year[11:0], month[15:12], day[20:16], hour[25:21],
                                  // minute[31:26]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // year[11:0], month[15:12], day[20:16], hour[25:21],
                                  // minute[31:26], row[33:32], cursor[36:34], zero fill
);

  logic        s1_valid_r;
  logic [2:0]  s1_kind_r;
  logic [31:0] s1_data_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic        advance;

  logic [1:0]  row_r, row_nxt;
  logic [2:0]  cursor_r, cursor_nxt;
  logic [11:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [4:0]  last_day;
  logic        time_row;

  // Handshake: output register frees when empty or taken
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign time_row = (row_r == dtfe_pkg::ROW_TIME);
  assign last_day = dtfe_pkg::month_last_day(month_r, year_r);

  // Next state for the word in the input register
  always_comb begin
    row_nxt    = row_r;
    cursor_nxt = cursor_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    unique case (s1_kind_r)
      dtfe_pkg::KIND_UP: begin
        row_nxt = (row_r == dtfe_pkg::ROW_TIME) ? dtfe_pkg::ROW_LAST : row_r - 2'd1;
      end
      dtfe_pkg::KIND_DOWN: begin
        row_nxt = (row_r >= dtfe_pkg::ROW_LAST) ? dtfe_pkg::ROW_TIME : row_r + 2'd1;
      end
      dtfe_pkg::KIND_LEFT: begin
        if (time_row) begin
          cursor_nxt = (cursor_r == dtfe_pkg::FLD_YEAR100) ? dtfe_pkg::FLD_LAST
                                                           : cursor_r - 3'd1;
        end
      end
      dtfe_pkg::KIND_RIGHT: begin
        if (time_row) begin
          cursor_nxt = (cursor_r >= dtfe_pkg::FLD_LAST) ? dtfe_pkg::FLD_YEAR100
                                                        : cursor_r + 3'd1;
        end
      end
      dtfe_pkg::KIND_INC: begin
        if (time_row) begin
          unique case (cursor_r)
            dtfe_pkg::FLD_YEAR100: begin
              if (year_r <= dtfe_pkg::YEAR100_UP_MAX) year_nxt = year_r + dtfe_pkg::YEAR_STEP100;
            end
            dtfe_pkg::FLD_YEAR10: begin
              if (year_r <= dtfe_pkg::YEAR10_UP_MAX) year_nxt = year_r + dtfe_pkg::YEAR_STEP10;
            end
            dtfe_pkg::FLD_YEAR1: begin
              if (year_r <= dtfe_pkg::YEAR1_UP_MAX) year_nxt = year_r + dtfe_pkg::YEAR_STEP1;
            end
            dtfe_pkg::FLD_MONTH: begin
              month_nxt = (month_r >= dtfe_pkg::MONTH_MAX) ? 4'd1 : month_r + 4'd1;
            end
            dtfe_pkg::FLD_DAY: begin
              // month code outside the calendar: leave the day alone
              if (last_day != 5'd0) day_nxt = (day_r >= last_day) ? 5'd1 : day_r + 5'd1;
            end
            dtfe_pkg::FLD_HOUR: begin
              hour_nxt = (hour_r >= dtfe_pkg::HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
            end
            dtfe_pkg::FLD_MINUTE: begin
              minute_nxt = (minute_r >= dtfe_pkg::MINUTE_MAX) ? 6'd0 : minute_r + 6'd1;
            end
            default: ;
          endcase
        end
      end
      dtfe_pkg::KIND_DEC: begin
        if (time_row) begin
          unique case (cursor_r)
            dtfe_pkg::FLD_YEAR100: begin
              if (year_r > dtfe_pkg::YEAR100_DN_MIN) year_nxt = year_r - dtfe_pkg::YEAR_STEP100;
            end
            dtfe_pkg::FLD_YEAR10: begin
              if (year_r > dtfe_pkg::YEAR10_DN_MIN) year_nxt = year_r - dtfe_pkg::YEAR_STEP10;
            end
            dtfe_pkg::FLD_YEAR1: begin
              if (year_r > dtfe_pkg::YEAR1_DN_MIN) year_nxt = year_r - dtfe_pkg::YEAR_STEP1;
            end
            dtfe_pkg::FLD_MONTH: begin
              month_nxt = (month_r <= 4'd1) ? dtfe_pkg::MONTH_MAX : month_r - 4'd1;
            end
            dtfe_pkg::FLD_DAY: begin
              if (last_day != 5'd0) day_nxt = (day_r <= 5'd1) ? last_day : day_r - 5'd1;
            end
            dtfe_pkg::FLD_HOUR: begin
              hour_nxt = (hour_r == 5'd0) ? dtfe_pkg::HOUR_MAX : hour_r - 5'd1;
            end
            dtfe_pkg::FLD_MINUTE: begin
              minute_nxt = (minute_r == 6'd0) ? dtfe_pkg::MINUTE_MAX : minute_r - 6'd1;
            end
            default: ;
          endcase
        end
      end
      dtfe_pkg::KIND_LOAD: begin
        year_nxt   = s1_data_r[11:0];
        month_nxt  = s1_data_r[15:12];
        day_nxt    = s1_data_r[20:16];
        hour_nxt   = s1_data_r[25:21];
        minute_nxt = s1_data_r[31:26];
      end
      dtfe_pkg::KIND_NONE: ;
    endcase
  end

  // Input register: take a word whenever there is room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  // Editor state: commit when the word moves into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= dtfe_pkg::ROW_TIME;
      cursor_r <= dtfe_pkg::FLD_YEAR100;
      year_r   <= dtfe_pkg::YEAR_RST;
      month_r  <= 4'd1;
      day_r    <= 5'd1;
      hour_r   <= 5'd0;
      minute_r <= 6'd0;
    end else if (s1_valid_r && advance) begin
      row_r    <= row_nxt;
      cursor_r <= cursor_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_valid_r && advance) begin
      out_data_r <= {3'd0, cursor_nxt, row_nxt, minute_nxt, hour_nxt, day_nxt,
                     month_nxt, year_nxt};
    end
  end

  // Row and cursor never reach codes outside their menus
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r != 2'd3)
    else $error("menu row reached an unused code");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r != 3'd7)
    else $error("field cursor reached an unused code");

  // A word leaving the input register always shows up at the output
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("result word lost on its way to the output");

  // Both registers full and stalled: no new word taken
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are full");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Date-time as it travels in in_tdata, lowest field last
  typedef struct packed {
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } load_word_t;

  // Editor state as it travels in out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]  fill;
    logic [2:0]  cursor;
    logic [1:0]  row;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } editor_state_t;

  // One line of the directed sequence; typed rows carry their own answer
  typedef struct packed {
    logic [2:0]    kind;
    load_word_t    ld;
    logic          typed;
    editor_state_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [2:0]  in_tuser;   // kind
  logic [31:0] in_tdata;   // year, month, day, hour, minute
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // year, month, day, hour, minute, row, cursor, zero fill

  editor_state_t ed;                // predicted editor state
  editor_state_t state_due_q[$];    // states still to come out of the block
  plan_row_t     plan_q[$];
  bit            gaps_on;
  int            fail_count;
  int            n_checked;
  int            n_loads, n_edits, n_cursor, n_rows, n_none;

  date_time_field_editor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Last day of a month, leap years every fourth year with no century rule
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [11:0] y);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     return 5'd30;
      4'd2:    return (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: return 5'd0;
    endcase
  endfunction

  // Step the field under the cursor; years saturate, the rest wrap
  task bump_field(input logic up);
    logic [4:0] last;
    last = days_in_month(ed.month, ed.year);
    case (ed.cursor)
      dtfe_pkg::FLD_YEAR100: begin
        if (up) begin
          if (ed.year <= 12'd2899) ed.year = ed.year + 12'd100;
        end else if (ed.year > 12'd1000) begin
          ed.year = ed.year - 12'd100;
        end
      end
      dtfe_pkg::FLD_YEAR10: begin
        if (up) begin
          if (ed.year <= 12'd2989) ed.year = ed.year + 12'd10;
        end else if (ed.year > 12'd100) begin
          ed.year = ed.year - 12'd10;
        end
      end
      dtfe_pkg::FLD_YEAR1: begin
        if (up) begin
          if (ed.year <= 12'd2998) ed.year = ed.year + 12'd1;
        end else if (ed.year > 12'd1) begin
          ed.year = ed.year - 12'd1;
        end
      end
      dtfe_pkg::FLD_MONTH: begin
        if (up) ed.month = (ed.month >= 4'd12) ? 4'd1 : ed.month + 4'd1;
        else    ed.month = (ed.month <= 4'd1) ? 4'd12 : ed.month - 4'd1;
      end
      dtfe_pkg::FLD_DAY: begin
        // a month outside the calendar freezes the day
        if (last != 5'd0) begin
          if (up) ed.day = (ed.day >= last) ? 5'd1 : ed.day + 5'd1;
          else    ed.day = (ed.day <= 5'd1) ? last : ed.day - 5'd1;
        end
      end
      dtfe_pkg::FLD_HOUR: begin
        if (up) ed.hour = (ed.hour >= 5'd23) ? 5'd0 : ed.hour + 5'd1;
        else    ed.hour = (ed.hour == 5'd0) ? 5'd23 : ed.hour - 5'd1;
      end
      dtfe_pkg::FLD_MINUTE: begin
        if (up) ed.minute = (ed.minute >= 6'd59) ? 6'd0 : ed.minute + 6'd1;
        else    ed.minute = (ed.minute == 6'd0) ? 6'd59 : ed.minute - 6'd1;
      end
      default: ;
    endcase
  endtask

  // Apply one button event or RTC load to the predicted state
  task step_editor(input logic [2:0] kind, input load_word_t ld);
    logic time_row;
    time_row = (ed.row == dtfe_pkg::ROW_TIME);
    case (kind)
      dtfe_pkg::KIND_UP: begin
        ed.row = (ed.row == dtfe_pkg::ROW_TIME) ? dtfe_pkg::ROW_LAST : ed.row - 2'd1;
      end
      dtfe_pkg::KIND_DOWN: begin
        ed.row = (ed.row >= dtfe_pkg::ROW_LAST) ? dtfe_pkg::ROW_TIME : ed.row + 2'd1;
      end
      dtfe_pkg::KIND_LEFT: begin
        if (time_row) ed.cursor = (ed.cursor == dtfe_pkg::FLD_YEAR100) ? dtfe_pkg::FLD_LAST
                                                                       : ed.cursor - 3'd1;
      end
      dtfe_pkg::KIND_RIGHT: begin
        if (time_row) ed.cursor = (ed.cursor >= dtfe_pkg::FLD_LAST) ? dtfe_pkg::FLD_YEAR100
                                                                    : ed.cursor + 3'd1;
      end
      dtfe_pkg::KIND_INC: if (time_row) bump_field(1'b1);
      dtfe_pkg::KIND_DEC: if (time_row) bump_field(1'b0);
      dtfe_pkg::KIND_LOAD: begin
        ed.year   = ld.year;
        ed.month  = ld.month;
        ed.day    = ld.day;
        ed.hour   = ld.hour;
        ed.minute = ld.minute;
      end
      default: ;
    endcase
  endtask

  function automatic load_word_t ld_word(input int y, input int m, input int d,
                                         input int h, input int mi);
    load_word_t w;
    w.year = 12'(y); w.month = 4'(m); w.day = 5'(d); w.hour = 5'(h); w.minute = 6'(mi);
    return w;
  endfunction

  function automatic editor_state_t st_word(input int y, input int m, input int d,
                                            input int h, input int mi,
                                            input logic [1:0] r, input logic [2:0] c);
    editor_state_t s;
    s = '0;
    s.year = 12'(y); s.month = 4'(m); s.day = 5'(d); s.hour = 5'(h); s.minute = 6'(mi);
    s.row = r; s.cursor = c;
    return s;
  endfunction

  function automatic string show_state(input editor_state_t s);
    return $sformatf("%0d-%0d-%0d %0d:%0d row %0d cursor %0d fill %0d",
                     s.year, s.month, s.day, s.hour, s.minute, s.row, s.cursor, s.fill);
  endfunction

  task plan(input logic [2:0] kind, input load_word_t ld, input logic typed,
            input editor_state_t want);
    plan_row_t p;
    p.kind = kind; p.ld = ld; p.typed = typed; p.want = want;
    plan_q.push_back(p);
  endtask

  // Date-time for a random load: mostly sane, often at the year limits
  function automatic load_word_t random_load();
    load_word_t w;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 15))
          0: w.year = 12'd0;     1: w.year = 12'd1;     2: w.year = 12'd2;
          3: w.year = 12'd99;    4: w.year = 12'd100;   5: w.year = 12'd101;
          6: w.year = 12'd999;   7: w.year = 12'd1000;  8: w.year = 12'd1001;
          9: w.year = 12'd2899;  10: w.year = 12'd2900; 11: w.year = 12'd2989;
          12: w.year = 12'd2990; 13: w.year = 12'd2998; 14: w.year = 12'd2999;
          default: w.year = 12'd3000;
        endcase
      end
      1:       w.year = 12'($urandom_range(0, 4095));
      default: w.year = 12'($urandom_range(1, 3000));
    endcase
    w.month  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 12));
    w.day    = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(1, 31));
    w.hour   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 23));
    w.minute = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 59));
    return w;
  endfunction

  // Pick an event; away from the time row, mostly head back to it
  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (ed.row != dtfe_pkg::ROW_TIME && r < 70) begin
      return (ed.row == dtfe_pkg::ROW_LAST) ? dtfe_pkg::KIND_DOWN : dtfe_pkg::KIND_UP;
    end
    if (r < 4)  return dtfe_pkg::KIND_UP;
    if (r < 8)  return dtfe_pkg::KIND_DOWN;
    if (r < 20) return dtfe_pkg::KIND_LEFT;
    if (r < 32) return dtfe_pkg::KIND_RIGHT;
    if (r < 60) return dtfe_pkg::KIND_INC;
    if (r < 88) return dtfe_pkg::KIND_DEC;
    if (r < 98) return dtfe_pkg::KIND_LOAD;
    return dtfe_pkg::KIND_NONE;
  endfunction

  // Offer one word, wait for it to be taken, then record the state it must yield
  task automatic send_word(input logic [2:0] kind, input logic [31:0] data,
                           input logic typed, input editor_state_t want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_editor(kind, data);
    state_due_q.push_back(typed ? want : ed);
    case (kind)
      dtfe_pkg::KIND_LOAD:                     n_loads++;
      dtfe_pkg::KIND_INC, dtfe_pkg::KIND_DEC:  n_edits++;
      dtfe_pkg::KIND_LEFT, dtfe_pkg::KIND_RIGHT: n_cursor++;
      dtfe_pkg::KIND_UP, dtfe_pkg::KIND_DOWN:  n_rows++;
      default:                                 n_none++;
    endcase
    @(negedge clk);
  endtask

  // Hold off the sender until every result has come back
  task drain;
    in_tvalid = 1'b0;
    while (state_due_q.size() != 0) @(negedge clk);
  endtask

  // Stall the receiver in short random bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // Check every word taken from the output against the oldest prediction
  always @(posedge clk) begin : watch_out
    editor_state_t got;
    editor_state_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (state_due_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected word: %s", show_state(got));
      end else begin
        want = state_due_q.pop_front();
        n_checked++;
        if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
            got.hour !== want.hour || got.minute !== want.minute ||
            got.row !== want.row || got.cursor !== want.cursor || got.fill !== want.fill) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch at %0t: expected %s, got %s", $realtime,
                     show_state(want), show_state(got));
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    plan_row_t     p;
    logic [2:0]    kind;
    logic [31:0]   data;
    editor_state_t none;

    none      = '0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = dtfe_pkg::KIND_NONE;
    in_tdata  = '0;
    gaps_on   = 1'b1;
    ed        = st_word(2000, 1, 1, 0, 0, dtfe_pkg::ROW_TIME, dtfe_pkg::FLD_YEAR100);

    // Directed sequence: limits, wraps, leap days, bad months, other rows
    plan(dtfe_pkg::KIND_NONE,  '0, 1'b1,
         st_word(2000, 1, 1, 0, 0, dtfe_pkg::ROW_TIME, dtfe_pkg::FLD_YEAR100));
    plan(dtfe_pkg::KIND_LOAD,  ld_word(2899, 2, 28, 23, 59), 1'b1,
         st_word(2899, 2, 28, 23, 59, dtfe_pkg::ROW_TIME, dtfe_pkg::FLD_YEAR100));
    plan(dtfe_pkg::KIND_INC,   '0, 1'b1,
         st_word(2999, 2, 28, 23, 59, dtfe_pkg::ROW_TIME, dtfe_pkg::FLD_YEAR100));
    plan(dtfe_pkg::KIND_INC,   '0, 1'b1,
         st_word(2999, 2, 28, 23, 59, dtfe_pkg::ROW_TIME, dtfe_pkg::FLD_YEAR100));
    plan(dtfe_pkg::KIND_DEC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_LEFT,  '0, 1'b0, none);
    plan(dtfe_pkg::KIND_INC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_DEC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_LEFT,  '0, 1'b0, none);
    plan(dtfe_pkg::KIND_INC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_LEFT,  '0, 1'b0, none);
    plan(dtfe_pkg::KIND_INC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_DEC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_LOAD,  ld_word(1900, 2, 29, 0, 0), 1'b1,
         st_word(1900, 2, 29, 0, 0, dtfe_pkg::ROW_TIME, dtfe_pkg::FLD_DAY));
    plan(dtfe_pkg::KIND_INC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_LEFT,  '0, 1'b0, none);
    plan(dtfe_pkg::KIND_DEC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_DEC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_LOAD,  ld_word(4095, 15, 31, 31, 63), 1'b1,
         st_word(4095, 15, 31, 31, 63, dtfe_pkg::ROW_TIME, dtfe_pkg::FLD_MONTH));
    plan(dtfe_pkg::KIND_INC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_LOAD,  ld_word(0, 0, 0, 0, 0), 1'b1,
         st_word(0, 0, 0, 0, 0, dtfe_pkg::ROW_TIME, dtfe_pkg::FLD_MONTH));
    plan(dtfe_pkg::KIND_RIGHT, '0, 1'b0, none);
    plan(dtfe_pkg::KIND_INC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_UP,    '0, 1'b0, none);
    plan(dtfe_pkg::KIND_RIGHT, '0, 1'b0, none);
    plan(dtfe_pkg::KIND_DEC,   '0, 1'b0, none);
    plan(dtfe_pkg::KIND_DOWN,  '0, 1'b0, none);

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan_q[i]) begin
      p = plan_q[i];
      send_word(p.kind, p.ld, p.typed, p.want);
    end
    drain();

    // Random events; quiet handshakes over the last stretch
    for (int i = 0; i < 1300; i++) begin
      if (i == 650) drain();
      if (i == 1000) gaps_on = 1'b0;
      kind = pick_kind();
      data = (kind == dtfe_pkg::KIND_LOAD) ? random_load() : $urandom();
      send_word(kind, data, 1'b0, none);
    end

    in_tvalid = 1'b0;
    while (state_due_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d words: %0d loads, %0d field steps, %0d cursor moves,",
             n_loads + n_edits + n_cursor + n_rows + n_none, n_loads, n_edits, n_cursor);
    $display("%0d row moves, %0d no-ops; compared %0d results, %0d failures",
             n_rows, n_none, n_checked, fail_count);
    if (fail_count == 0 && state_due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/dtfe_pkg.sv
design/date_time_field_editor.sv
tb/testbench.sv
